[src/kmdg_pkg.sv]
// Shared types and constants of the keypoint minimum-distance grid filter.
package kmdg_pkg;

    // Occupancy grid size in cells and fixed-point format of positions.
    localparam int GRID_COLS       = 256;
    localparam int GRID_ROWS       = 256;
    localparam int COORD_FRAC_BITS = 4;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int IMG_W   = 12;
    localparam int MD_W    = 8;
    localparam int PATCH_W = 6;
    localparam int STR_W   = 16;
    localparam int ANG_W   = 10;
    localparam int OCT_W   = 4;
    localparam int NUM_W   = 32;
    localparam int LIM_W   = 16;

    localparam int CELL_W      = MD_W - 1;
    localparam int HALF_W      = PATCH_W - 1;
    localparam int COORD_INT_W = COORD_W - COORD_FRAC_BITS;

    // Dividend width of the cell divider: the larger of a pixel position and an image size.
    localparam int DIV_W     = (COORD_INT_W > IMG_W) ? COORD_INT_W : IMG_W;
    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = (DIV_W + DIV_RADIX - 1) / DIV_RADIX;
    localparam int DIV_PAD   = DIV_STEPS * DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int BORDER_W = DIV_W + 1;

    // Grid addressing and grid size limits.
    localparam int DIM_CAP   = 4095;
    localparam int COL_CAP   = (GRID_COLS < DIM_CAP) ? GRID_COLS : DIM_CAP;
    localparam int ROW_CAP   = (GRID_ROWS < DIM_CAP) ? GRID_ROWS : DIM_CAP;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_DIM_W = $clog2(COL_CAP + 1);
    localparam int ROW_DIM_W = $clog2(ROW_CAP + 1);
    localparam int DIM_MAX_W = (COL_DIM_W > ROW_DIM_W) ? COL_DIM_W : ROW_DIM_W;
    localparam int CLAMP_W   = (DIV_PAD > DIM_MAX_W) ? DIV_PAD : DIM_MAX_W;

    // Stream and configuration port widths.
    localparam int IN_FIELDS_W  = 2 * COORD_W + STR_W + ANG_W + OCT_W + NUM_W + LIM_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = NUM_W + 2 * COORD_W + STR_W + ANG_W + OCT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = IMG_W;

    localparam logic [IMG_W-1:0] WIDTH_RESET  = IMG_W'(640);
    localparam logic [IMG_W-1:0] HEIGHT_RESET = IMG_W'(480);

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_START    = 1'b0,
        CMD_KEYPOINT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DIST = 2'd0,
        REG_PATCH    = 2'd1,
        REG_WIDTH    = 2'd2,
        REG_HEIGHT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MD_W-1:0]    min_dist;
        logic [PATCH_W-1:0] patch_size;
        logic [IMG_W-1:0]   image_width;
        logic [IMG_W-1:0]   image_height;
    } t_cfg;

    typedef struct packed {
        t_cmd                    cmd;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic signed [STR_W-1:0] strength;
        logic signed [ANG_W-1:0] angle;
        logic [OCT_W-1:0]        octave;
        logic [NUM_W-1:0]        first_number;
        logic [LIM_W-1:0]        limit;
    } t_item;

    // One classified request handed from the front part to the back part.
    typedef struct packed {
        logic                 filter;
        logic [DIV_PAD-1:0]   cx;
        logic [DIV_PAD-1:0]   cy;
        logic [COL_DIM_W-1:0] gcols;
        logic [ROW_DIM_W-1:0] grows;
        t_item                item;
    } t_job;

    typedef struct packed {
        logic [NUM_W-1:0]        number;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic signed [STR_W-1:0] strength;
        logic signed [ANG_W-1:0] angle;
        logic [OCT_W-1:0]        octave;
        logic                    last;
    } t_result;

endpackage

[src/kmdg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kmdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/kmdg_div.sv]
// Multi-cycle restoring divider that finds cell indexes and grid sizes.
module kmdg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [kmdg_pkg::DIV_W-1:0]  i_num,
    input  logic [kmdg_pkg::CELL_W-1:0] i_den,
    output logic                       o_done,
    output logic [kmdg_pkg::DIV_PAD-1:0] o_quot
);
    import kmdg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_PAD-1:0]   r_num;
    logic [DIV_PAD-1:0]   r_quot;
    logic [CELL_W-1:0]    r_rem;
    logic [CELL_W-1:0]    r_den;

    logic [DIV_PAD-1:0]   n_num;
    logic [DIV_PAD-1:0]   n_quot;
    logic [CELL_W-1:0]    n_rem;

    // Several quotient bits per cycle, most significant first.
    always_comb begin
        logic [CELL_W:0] t;
        logic [CELL_W:0] diff;
        n_num  = r_num;
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int k = 0; k < DIV_RADIX; k++) begin
            t     = {n_rem, n_num[DIV_PAD-1]};
            n_num = {n_num[DIV_PAD-2:0], 1'b0};
            diff  = t - {1'b0, r_den};
            if (t >= {1'b0, r_den}) begin
                n_rem  = diff[CELL_W-1:0];
                n_quot = {n_quot[DIV_PAD-2:0], 1'b1};
            end else begin
                n_rem  = t[CELL_W-1:0];
                n_quot = {n_quot[DIV_PAD-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num  <= DIV_PAD'(i_num);
            r_quot <= '0;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[src/kmdg_fifo.sv]
// Short request queue between the classifying front part and the grid back part.
module kmdg_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kmdg_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output kmdg_pkg::t_job o_job,
    output logic           o_empty
);
    import kmdg_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

[src/kmdg_front.sv]
// Front part: takes requests, applies the border test and computes cell indexes or grid sizes.
module kmdg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kmdg_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  kmdg_pkg::t_item i_item,
    output logic            o_push,
    output kmdg_pkg::t_job  o_job,
    input  logic            i_full
);
    import kmdg_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_EVAL,
        F_DIV,
        F_PUSH
    } t_fstate;

    t_fstate r_state;
    t_fstate n_state;
    t_item   r_item;
    t_item   n_item;
    t_job    r_job;
    t_job    n_job;

    logic                   filter;
    logic [CELL_W-1:0]      cell_px;
    logic [HALF_W-1:0]      half;
    logic [COORD_INT_W-1:0] px;
    logic [COORD_INT_W-1:0] py;
    logic                   in_x;
    logic                   in_y;
    logic                   is_start;
    logic                   keep;
    logic [DIV_W-1:0]       num_x;
    logic [DIV_W-1:0]       num_y;
    logic                   div_start;
    logic                   div_done;
    logic                   div_done_y;
    logic [DIV_PAD-1:0]     quot_x;
    logic [DIV_PAD-1:0]     quot_y;
    logic [COL_DIM_W-1:0]   dim_cols;
    logic [ROW_DIM_W-1:0]   dim_rows;

    assign filter   = i_cfg.min_dist > MD_W'(1);
    assign cell_px  = i_cfg.min_dist[MD_W-1:1];
    assign half     = i_cfg.patch_size[PATCH_W-1:1];
    assign px       = r_item.x[COORD_W-1:COORD_FRAC_BITS];
    assign py       = r_item.y[COORD_W-1:COORD_FRAC_BITS];
    assign is_start = (r_item.cmd == CMD_START);

    // The whole patch must lie strictly inside the image.
    assign in_x = (BORDER_W'(px) > BORDER_W'(half))
               && (BORDER_W'(px) + BORDER_W'(half) < BORDER_W'(i_cfg.image_width));
    assign in_y = (BORDER_W'(py) > BORDER_W'(half))
               && (BORDER_W'(py) + BORDER_W'(half) < BORDER_W'(i_cfg.image_height));
    assign keep = is_start || (in_x && in_y);

    // A start divides the image size, a keypoint its integer pixel position.
    assign num_x = is_start ? DIV_W'(i_cfg.image_width)  : DIV_W'(px);
    assign num_y = is_start ? DIV_W'(i_cfg.image_height) : DIV_W'(py);

    kmdg_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_x),
        .i_den   (cell_px),
        .o_done  (div_done),
        .o_quot  (quot_x)
    );

    kmdg_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_y),
        .i_den   (cell_px),
        .o_done  (div_done_y),
        .o_quot  (quot_y)
    );

    // Grid size is one more than the quotient, saturated to the bitmap size.
    assign dim_cols = ((DIV_PAD + 1)'(quot_x) >= (DIV_PAD + 1)'(COL_CAP))
                    ? COL_DIM_W'(COL_CAP) : COL_DIM_W'(quot_x) + COL_DIM_W'(1);
    assign dim_rows = ((DIV_PAD + 1)'(quot_y) >= (DIV_PAD + 1)'(ROW_CAP))
                    ? ROW_DIM_W'(ROW_CAP) : ROW_DIM_W'(quot_y) + ROW_DIM_W'(1);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_job     = r_job;
        div_start = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_item  = i_item;
                    n_state = F_EVAL;
                end
            end
            F_EVAL: begin
                n_job.item   = r_item;
                n_job.filter = filter;
                n_job.cx     = '0;
                n_job.cy     = '0;
                n_job.gcols  = COL_DIM_W'(1);
                n_job.grows  = ROW_DIM_W'(1);
                if (!keep) begin
                    n_state = F_IDLE;
                end else if (filter) begin
                    div_start = 1'b1;
                    n_state   = F_DIV;
                end else begin
                    n_state = F_PUSH;
                end
            end
            F_DIV: begin
                if (div_done && div_done_y) begin
                    if (r_job.item.cmd == CMD_START) begin
                        n_job.gcols = dim_cols;
                        n_job.grows = dim_rows;
                    end else begin
                        n_job.cx = quot_x;
                        n_job.cy = quot_y;
                    end
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    if (i_valid) begin
                        n_item  = i_item;
                        n_state = F_EVAL;
                    end else begin
                        n_state = F_IDLE;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_job  <= n_job;
    end

    assign o_ready = (r_state == F_IDLE) || ((r_state == F_PUSH) && !i_full);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_job   = r_job;

endmodule

[src/kmdg_back.sv]
// Back part: frame state, occupancy grid updates and the result register.
module kmdg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  kmdg_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output kmdg_pkg::t_result o_result
);
    import kmdg_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_UP,
        B_DOWN,
        B_EMIT
    } t_bstate;

    t_bstate              r_state;
    t_bstate              n_state;
    t_job                 r_job;
    t_job                 n_job;
    logic [COL_W-1:0]     r_cx;
    logic [COL_W-1:0]     n_cx;
    logic [ROW_W-1:0]     r_cy;
    logic [ROW_W-1:0]     n_cy;
    logic                 r_rd_valid;
    logic                 n_rd_valid;
    logic [GRID_ROWS-1:0] r_row_valid;
    logic [GRID_ROWS-1:0] n_row_valid;
    logic [LIM_W-1:0]     r_count;
    logic [LIM_W-1:0]     n_count;
    logic [LIM_W-1:0]     r_limit;
    logic [LIM_W-1:0]     n_limit;
    logic [NUM_W-1:0]     r_next_num;
    logic [NUM_W-1:0]     n_next_num;
    logic [COL_DIM_W-1:0] r_gcols;
    logic [COL_DIM_W-1:0] n_gcols;
    logic [ROW_DIM_W-1:0] r_grows;
    logic [ROW_DIM_W-1:0] n_grows;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic [GRID_COLS-1:0] ram_q;
    logic [GRID_COLS-1:0] row;
    logic [GRID_COLS-1:0] bit_c;
    logic [GRID_COLS-1:0] mask3;
    logic [COL_DIM_W-1:0] col_last;
    logic [ROW_DIM_W-1:0] row_last;
    logic [COL_W-1:0]     cx_clamp;
    logic [ROW_W-1:0]     cy_clamp;
    logic [ROW_W-1:0]     cy_up;
    logic [ROW_W-1:0]     cy_dn;
    logic                 has_right;
    logic                 has_down;
    logic                 limit_hit;
    logic [LIM_W-1:0]     count_inc;

    kmdg_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    assign col_last = r_gcols - COL_DIM_W'(1);
    assign row_last = r_grows - ROW_DIM_W'(1);

    // Cell indexes past the grid land on the last column or row.
    assign cx_clamp = (CLAMP_W'(i_job.cx) > CLAMP_W'(col_last))
                    ? COL_W'(col_last) : COL_W'(i_job.cx);
    assign cy_clamp = (CLAMP_W'(i_job.cy) > CLAMP_W'(row_last))
                    ? ROW_W'(row_last) : ROW_W'(i_job.cy);

    assign cy_up     = r_cy - ROW_W'(1);
    assign cy_dn     = r_cy + ROW_W'(1);
    assign has_right = COL_DIM_W'(r_cx) < col_last;
    assign has_down  = ROW_DIM_W'(r_cy) < row_last;

    // A row never written since the last start reads as empty.
    assign row   = r_rd_valid ? ram_q : '0;
    assign bit_c = GRID_COLS'(1) << r_cx;
    assign mask3 = bit_c
                 | ((r_cx != '0) ? (bit_c >> 1) : '0)
                 | (has_right ? (bit_c << 1) : '0);

    assign limit_hit = (r_limit != '0) && (r_count >= r_limit);
    assign count_inc = (r_count == '1) ? r_count : r_count + LIM_W'(1);

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rd_valid  = r_rd_valid;
        n_row_valid = r_row_valid;
        n_count     = r_count;
        n_limit     = r_limit;
        n_next_num  = r_next_num;
        n_gcols     = r_gcols;
        n_grows     = r_grows;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.item.cmd == CMD_START) begin
                        n_row_valid = '0;
                        n_next_num  = i_job.item.first_number;
                        n_limit     = i_job.item.limit;
                        n_count     = '0;
                        n_gcols     = i_job.gcols;
                        n_grows     = i_job.grows;
                    end else if (!limit_hit) begin
                        n_job = i_job;
                        n_cx  = cx_clamp;
                        n_cy  = cy_clamp;
                        if (i_job.filter) begin
                            rd_en      = 1'b1;
                            rd_addr    = cy_clamp;
                            n_rd_valid = r_row_valid[cy_clamp];
                            n_state    = B_CHECK;
                        end else begin
                            n_state = B_EMIT;
                        end
                    end
                end
            end
            B_CHECK: begin
                if (row[r_cx]) begin
                    n_state = B_IDLE;
                end else begin
                    wr_en             = 1'b1;
                    wr_addr           = r_cy;
                    wr_data           = row | mask3;
                    n_row_valid[r_cy] = 1'b1;
                    if (r_cy != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = cy_up;
                        n_rd_valid = r_row_valid[cy_up];
                        n_state    = B_UP;
                    end else if (has_down) begin
                        rd_en      = 1'b1;
                        rd_addr    = cy_dn;
                        n_rd_valid = r_row_valid[cy_dn];
                        n_state    = B_DOWN;
                    end else begin
                        n_state = B_EMIT;
                    end
                end
            end
            B_UP: begin
                wr_en              = 1'b1;
                wr_addr            = cy_up;
                wr_data            = row | bit_c;
                n_row_valid[cy_up] = 1'b1;
                if (has_down) begin
                    rd_en      = 1'b1;
                    rd_addr    = cy_dn;
                    n_rd_valid = r_row_valid[cy_dn];
                    n_state    = B_DOWN;
                end else begin
                    n_state = B_EMIT;
                end
            end
            B_DOWN: begin
                wr_en              = 1'b1;
                wr_addr            = cy_dn;
                wr_data            = row | bit_c;
                n_row_valid[cy_dn] = 1'b1;
                n_state            = B_EMIT;
            end
            B_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid    = 1'b1;
                    n_out.number   = r_next_num;
                    n_out.x        = r_job.item.x;
                    n_out.y        = r_job.item.y;
                    n_out.strength = r_job.item.strength;
                    n_out.angle    = r_job.item.angle;
                    n_out.octave   = r_job.item.octave;
                    n_out.last     = (r_limit != '0) && (count_inc >= r_limit);
                    n_count        = count_inc;
                    n_next_num     = r_next_num + NUM_W'(1);
                    n_state        = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_row_valid <= '0;
            r_count     <= '0;
            r_limit     <= '0;
            r_next_num  <= '0;
            r_gcols     <= COL_DIM_W'(1);
            r_grows     <= ROW_DIM_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_next_num  <= n_next_num;
            r_gcols     <= n_gcols;
            r_grows     <= n_grows;
            r_out_valid <= n_out_valid;
        end
        r_job      <= n_job;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_rd_valid <= n_rd_valid;
        r_out      <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[src/keypoint_min_distance_grid_filter.sv]
// Top level of the keypoint minimum-distance grid filter.
//
// The block thins out a stream of corner keypoints that arrive strongest first. A start
// request (tuser low) opens a frame: it clears the occupancy grid, loads the number of the
// first feature and the feature limit, and sizes the grid from the image size and the
// minimum distance. Each keypoint request (tuser high) is dropped when its patch would cross
// the image border, when the limit is already reached, or, with a minimum distance above
// one, when its grid cell is taken; otherwise it marks its cell and the four neighbors and
// leaves with the next feature number, tlast marking the feature that fills the limit.
// A front part accepts and classifies requests, a two-entry queue decouples it from the
// back part, and the back part owns the grid RAM and the output register. A request that
// needs the cell divider (a keypoint or a start while the minimum distance is above one)
// holds the front part through the three divider steps and their completion, and the
// front part takes no new request until it is through. A grid keypoint then takes a row
// read and up to three row read-modify-writes in the back part. Every other kept request
// passes through the evaluate and push states, and the next request is taken in the push
// state as the last one is pushed. A stalled receiver holds the back part on its output
// register and, once the queue fills, the input. Right after reset and after every start
// the grid reads as empty through per-row valid bits, so there is no clearing pass.
// Configuration writes are always taken and must only be issued while the block is idle.
module keypoint_min_distance_grid_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kmdg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kmdg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Request stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: x_pos, y_pos, strength, angle_deg, octave_level, first_number, feature_limit
    input  logic [kmdg_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: command
    input  logic                              i_s_axis_tuser,
    // Feature stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: feature_number, out_x, out_y, out_strength, out_angle, out_octave
    output logic [kmdg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // tlast: limit_reached
    output logic                              o_m_axis_tlast
);
    import kmdg_pkg::*;

    // Bit offsets of the request fields in tdata.
    localparam int IX_X   = 0;
    localparam int IX_Y   = IX_X + COORD_W;
    localparam int IX_STR = IX_Y + COORD_W;
    localparam int IX_ANG = IX_STR + STR_W;
    localparam int IX_OCT = IX_ANG + ANG_W;
    localparam int IX_NUM = IX_OCT + OCT_W;
    localparam int IX_LIM = IX_NUM + NUM_W;

    logic [MD_W-1:0]    r_min_dist;
    logic [PATCH_W-1:0] r_patch;
    logic [IMG_W-1:0]   r_width;
    logic [IMG_W-1:0]   r_height;

    t_cfg    cfg;
    t_item   item;
    t_job    push_job;
    t_job    head_job;
    t_result result;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;

    // Configuration registers; writes to them are accepted in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= '0;
            r_patch    <= '0;
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MIN_DIST: r_min_dist <= i_cfg_data[MD_W-1:0];
                REG_PATCH:    r_patch    <= i_cfg_data[PATCH_W-1:0];
                REG_WIDTH:    r_width    <= i_cfg_data[IMG_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[IMG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.min_dist     = r_min_dist;
    assign cfg.patch_size   = r_patch;
    assign cfg.image_width  = r_width;
    assign cfg.image_height = r_height;

    // Unpack the request.
    assign item.cmd          = t_cmd'(i_s_axis_tuser);
    assign item.x            = i_s_axis_tdata[IX_X +: COORD_W];
    assign item.y            = i_s_axis_tdata[IX_Y +: COORD_W];
    assign item.strength     = i_s_axis_tdata[IX_STR +: STR_W];
    assign item.angle        = i_s_axis_tdata[IX_ANG +: ANG_W];
    assign item.octave       = i_s_axis_tdata[IX_OCT +: OCT_W];
    assign item.first_number = i_s_axis_tdata[IX_NUM +: NUM_W];
    assign item.limit        = i_s_axis_tdata[IX_LIM +: LIM_W];

    kmdg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (item),
        .o_push  (q_push),
        .o_job   (push_job),
        .i_full  (q_full)
    );

    kmdg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    kmdg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (head_job),
        .o_pop    (q_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    // Pack the feature, feature number in the lowest bits.
    assign o_m_axis_tdata = OUT_DATA_W'({result.octave, result.angle, result.strength,
                                         result.y, result.x, result.number});
    assign o_m_axis_tlast = result.last;

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("request queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("request queue read while empty");

    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("feature presented right after reset");

endmodule
